FILE: hdl/lssp_pkg.sv
// lssp_pkg: shared types and constants for the scan stream parser
// no dependencies
package lssp_pkg;

	localparam int POINTS_PER_CAPSULE = 40;
	localparam int FULL_CIRCLE_Q6 = 23040;
	localparam int CAPSULE_BYTES = 84;
	localparam int PT_IDX_W = 6;

	localparam logic [1:0] FMT_STANDARD = 2'd1;
	localparam logic [1:0] FMT_DENSE = 2'd2;

	localparam logic [3:0] HDR_SYNC1 = 4'hA;
	localparam logic [3:0] HDR_SYNC2 = 4'h5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_WAIT
	} emit_state_t;

	typedef struct packed {
		logic [14:0] angle_q6;
		logic [17:0] distance_q2;
		logic [5:0] quality;
		logic new_scan;
		logic last_of_run;
	} point_t;

endpackage

FILE: hdl/lssp_dist_mem.sv
// lssp_dist_mem: byte-wide distance store, two banks of one capsule each
// low and high byte of each distance sit in adjacent entries; depends on lssp_pkg
module lssp_dist_mem import lssp_pkg::*; #(
	parameter int DEPTH = POINTS_PER_CAPSULE
) (
	input logic clk,
	input logic wr_en,
	input logic wr_bank,
	input logic [$clog2(2*DEPTH)-1:0] wr_addr,
	input logic [7:0] wr_data,
	input logic rd_bank,
	input logic [$clog2(2*DEPTH)-1:0] rd_addr,
	output logic [7:0] rd_data
);

	logic [7:0] mem_q [2][2*DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_bank][wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_bank][rd_addr];
	end

endmodule

FILE: hdl/lidar_scan_stream_parser_unit.sv
// lidar_scan_stream_parser_unit: byte stream to measurement points, standard and dense modes
// depends on lssp_pkg, lssp_dist_mem
//
// One received byte is taken per beat. Standard nodes and bytes that finish no
// capsule do not hold the input while the output keeps up. A good dense capsule
// without the sync bit and with a pending one emits the pending capsule's 40
// points, two byte reads of the distance memory each, so that byte holds the
// input through the emission plus any output stall; the next byte is held until
// the last point is registered. Distances live in a two-bank memory: one bank holds
// the pending capsule while the other drains and refills; they swap per good capsule.
module lidar_scan_stream_parser_unit import lssp_pkg::*; #(
	parameter int FULL_CIRCLE = FULL_CIRCLE_Q6
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] rx_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [14:0] angle_q6,
	output logic [17:0] distance_q2,
	output logic [5:0] quality,
	output logic new_scan,
	output logic [15:0] points_in_revolution,
	output logic [15:0] checksum_fail_count,
	output logic last_of_run
);

	localparam int AW = $clog2(POINTS_PER_CAPSULE);
	localparam logic [15:0] FC = 16'(FULL_CIRCLE);
	localparam logic [AW-1:0] LAST_PT = AW'(POINTS_PER_CAPSULE - 1);

	emit_state_t state_q, state_d;
	logic [1:0] fmt_q;
	logic [39:0] win_q;
	logic [2:0] nfill_q;
	logic [6:0] cfill_q;
	logic [15:0] hdr_q;
	logic [7:0] xor_q;
	logic [15:0] cstart_q;
	logic [14:0] pstart_q;
	logic psync_q, pvalid_q;
	logic [14:0] estart_q;
	logic esync_q;
	logic [14:0] prev_ang_q;
	logic prev_valid_q;
	logic [15:0] rev_q, fail_q;
	logic bank_q;
	logic [AW-1:0] idx_q;
	logic [15:0] diff_q;
	logic [21:0] acc_q;
	logic rd_ok_s1;
	logic [AW-1:0] rd_idx_s1;
	logic [14:0] rd_ang_s1;
	logic rd_phase_q;
	logic [7:0] lo_q;

	// output register
	logic ov_q;
	point_t pt_q;
	logic [15:0] orev_q, ofail_q;

	logic accept;
	logic [39:0] win_n;
	logic node_ok;
	logic [15:0] node_raw;
	logic [14:0] node_ang;
	logic [7:0] xor_n;
	logic cap_done, cap_good;
	logic [15:0] new_start;
	logic [14:0] start_mod;
	logic mem_we;
	logic [6:0] didx;
	logic [15:0] diff_n;
	logic emit_go;
	logic [15:0] interp;
	logic [14:0] cur_ang;
	logic out_free;
	logic rd_issue;
	logic [AW:0] mem_raddr;
	logic [7:0] byte_rd;

	// point bookkeeping
	logic pp_go;
	logic [14:0] pp_ang;
	logic pp_force;
	logic pp_ns;
	logic [15:0] pp_rev;
	logic [15:0] pp_fail;

	assign out_free = !ov_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign accept = in_valid && in_ready;

	assign win_n = {win_q[31:0], rx_byte};
	assign node_raw = {win_n[23:16], win_n[31:24]} >> 1;
	assign node_ang = (node_raw >= FC) ? 15'(node_raw - FC) : node_raw[14:0];
	assign node_ok = (fmt_q == FMT_STANDARD) && (nfill_q >= 3'd4) &&
		win_n[24] && (win_n[32] != win_n[33]);

	assign xor_n = xor_q ^ rx_byte;
	assign didx = cfill_q - 7'd4;
	assign mem_we = accept && (fmt_q == FMT_DENSE) && (cfill_q >= 7'd4);
	assign cap_done = accept && (fmt_q == FMT_DENSE) && (cfill_q == 7'(CAPSULE_BYTES - 1));
	assign cap_good = cap_done && (xor_n == {hdr_q[11:8], hdr_q[3:0]});
	assign new_start = cstart_q;
	assign start_mod = ({1'b0, new_start[14:0]} >= FC) ?
		15'({1'b0, new_start[14:0]} - FC) : new_start[14:0];
	assign diff_n = ({1'b0, start_mod} >= {1'b0, pstart_q}) ?
		16'({1'b0, start_mod} - {1'b0, pstart_q}) :
		16'({1'b0, start_mod} + FC - {1'b0, pstart_q});
	assign emit_go = cap_good && pvalid_q && !new_start[15];

	// acc holds diff*i, divide by 40 as (acc>>3)/5 by reciprocal multiply
	assign interp = 16'((36'(acc_q[21:3]) * 36'd104858) >> 19);
	assign cur_ang = ({1'b0, estart_q} + interp >= FC) ?
		15'({1'b0, estart_q} + interp - FC) : 15'({1'b0, estart_q} + interp);

	// low byte and high byte of a distance are separate entries
	assign rd_issue = (state_q == ST_EMIT) && !rd_ok_s1 && !rd_phase_q;
	assign mem_raddr = {idx_q, rd_phase_q};

	lssp_dist_mem #(
		.DEPTH(POINTS_PER_CAPSULE)
	) u_mem (
		.clk(clk),
		.wr_en(mem_we),
		.wr_bank(bank_q),
		.wr_addr(didx),
		.wr_data(rx_byte),
		.rd_bank(bank_q),
		.rd_addr(mem_raddr),
		.rd_data(byte_rd)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (emit_go) state_d = ST_EMIT;
			ST_EMIT: if (pp_go && rd_idx_s1 == LAST_PT) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		if (cfg_we) state_d = ST_IDLE;
	end

	// point generation
	always_comb begin
		pp_go = 1'b0;
		pp_ang = node_ang;
		pp_force = win_n[32];
		if (accept && node_ok) begin
			pp_go = 1'b1;
		end else if (state_q == ST_EMIT && rd_ok_s1 && rd_phase_q && out_free) begin
			pp_go = 1'b1;
			pp_ang = rd_ang_s1;
			pp_force = esync_q && (rd_idx_s1 == '0);
		end
		pp_ns = pp_force || (prev_valid_q && (prev_ang_q > pp_ang) &&
			({1'b0, prev_ang_q - pp_ang} << 1) > {1'b0, FC});
		pp_rev = pp_ns ? 16'd1 : ((rev_q == 16'hFFFF) ? rev_q : rev_q + 16'd1);
		pp_fail = fail_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fmt_q <= '0;
			win_q <= '0;
			nfill_q <= '0;
			cfill_q <= '0;
			hdr_q <= '0;
			xor_q <= '0;
			cstart_q <= '0;
			pstart_q <= '0;
			psync_q <= 1'b0;
			pvalid_q <= 1'b0;
			estart_q <= '0;
			esync_q <= 1'b0;
			prev_ang_q <= '0;
			prev_valid_q <= 1'b0;
			rev_q <= '0;
			fail_q <= '0;
			bank_q <= 1'b0;
			idx_q <= '0;
			diff_q <= '0;
			acc_q <= '0;
			rd_ok_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			rd_ang_s1 <= '0;
			rd_phase_q <= 1'b0;
			lo_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pp_go && !cfg_we) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			if (cfg_we) begin
				fmt_q <= cfg_wdata;
				nfill_q <= '0;
				cfill_q <= '0;
				pvalid_q <= 1'b0;
				prev_valid_q <= 1'b0;
				rev_q <= '0;
				fail_q <= '0;
				rd_ok_s1 <= 1'b0;
				rd_phase_q <= 1'b0;
			end else begin
				if (accept && fmt_q == FMT_STANDARD) begin
					win_q <= win_n;
					if (node_ok) nfill_q <= '0;
					else if (nfill_q < 3'd5) nfill_q <= nfill_q + 3'd1;
				end
				if (accept && fmt_q == FMT_DENSE) begin
					if (cfill_q == 7'd0) begin
						if (rx_byte[7:4] == HDR_SYNC1) begin
							hdr_q <= {8'h00, rx_byte};
							cfill_q <= 7'd1;
						end
					end else if (cfill_q == 7'd1) begin
						if (rx_byte[7:4] == HDR_SYNC2) begin
							hdr_q[15:8] <= rx_byte;
							xor_q <= '0;
							cfill_q <= 7'd2;
						end else if (rx_byte[7:4] == HDR_SYNC1) begin
							hdr_q <= {8'h00, rx_byte};
						end else begin
							cfill_q <= '0;
						end
					end else begin
						xor_q <= xor_n;
						if (cfill_q == 7'd2) cstart_q[7:0] <= rx_byte;
						if (cfill_q == 7'd3) cstart_q[15:8] <= rx_byte;
						cfill_q <= cap_done ? 7'd0 : cfill_q + 7'd1;
					end
					if (cap_done && !cap_good && fail_q != 16'hFFFF)
						fail_q <= fail_q + 16'd1;
					if (cap_good) begin
						bank_q <= !bank_q;
						pstart_q <= start_mod;
						psync_q <= new_start[15];
						pvalid_q <= 1'b1;
						if (emit_go) begin
							idx_q <= '0;
							diff_q <= diff_n;
							acc_q <= '0;
							estart_q <= pstart_q;
							esync_q <= psync_q;
						end
					end
				end
				// emit sequencer: two byte reads per point
				if (state_q == ST_EMIT) begin
					if (rd_issue) begin
						rd_phase_q <= 1'b1;
						rd_idx_s1 <= idx_q;
						rd_ang_s1 <= cur_ang;
					end else if (rd_phase_q && !rd_ok_s1) begin
						lo_q <= byte_rd;
						rd_ok_s1 <= 1'b1;
					end else if (rd_ok_s1 && rd_phase_q && out_free) begin
						rd_ok_s1 <= 1'b0;
						rd_phase_q <= 1'b0;
						idx_q <= idx_q + AW'(1);
						acc_q <= acc_q + 22'(diff_q);
					end
				end
				if (pp_go) begin
					prev_ang_q <= pp_ang;
					prev_valid_q <= 1'b1;
					rev_q <= pp_rev;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pp_go) begin
			pt_q.angle_q6 <= pp_ang;
			pt_q.new_scan <= pp_ns;
			orev_q <= pp_rev;
			ofail_q <= (cap_done && !cap_good && fail_q != 16'hFFFF) ?
				fail_q + 16'd1 : pp_fail;
			if (accept && node_ok) begin
				pt_q.distance_q2 <= {2'b00, win_n[7:0], win_n[15:8]};
				pt_q.quality <= win_n[39:34];
				pt_q.last_of_run <= 1'b1;
			end else begin
				pt_q.distance_q2 <= {byte_rd, lo_q, 2'b00};
				pt_q.quality <= '0;
				pt_q.last_of_run <= (rd_idx_s1 == LAST_PT);
			end
		end
	end

	assign out_valid = ov_q;
	assign angle_q6 = pt_q.angle_q6;
	assign distance_q2 = pt_q.distance_q2;
	assign quality = pt_q.quality;
	assign new_scan = pt_q.new_scan;
	assign points_in_revolution = orev_q;
	assign checksum_fail_count = ofail_q;
	assign last_of_run = pt_q.last_of_run;

	a_no_accept_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> !in_ready) else $error("byte taken during emit");
	a_emit_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_EMIT) |-> pvalid_q) else $error("emit without pending");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		cfill_q < 7'(CAPSULE_BYTES)) else $error("capsule fill overrun");

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking bench for lidar_scan_stream_parser_unit, standard and dense modes
// depends on lssp_pkg and the parser rtl; point predictor and scoreboard class in this file
module tb_top;
	import lssp_pkg::*;

	typedef struct packed {
		logic [14:0] angle;
		logic [17:0] distance;
		logic [5:0] qual;
		logic nscan;
		logic [15:0] rev_pts;
		logic [15:0] fails;
		logic last;
	} scan_point_t;

	class point_scoreboard;
		logic [1:0] fmt;
		logic [39:0] window;
		int unsigned nfill, cfill, hdr, cxor, cstart;
		int unsigned incoming [POINTS_PER_CAPSULE];
		int unsigned pend_dist [POINTS_PER_CAPSULE];
		int unsigned pend_start, prev_ang, rev_cnt, fail_cnt, good_cnt;
		bit pend_sync, pend_ok, prev_ok;
		scan_point_t expected_points[$];
		int errors;

		function new();
			fmt = 0; window = 0; hdr = 0; cxor = 0; cstart = 0;
			pend_start = 0; pend_sync = 0; prev_ang = 0; errors = 0;
			foreach (incoming[i]) begin
				incoming[i] = 0;
				pend_dist[i] = 0;
			end
			clear();
		endfunction

		function void clear();
			nfill = 0; cfill = 0; pend_ok = 0; prev_ok = 0;
			rev_cnt = 0; fail_cnt = 0; good_cnt = 0;
		endfunction

		function void set_format(logic [1:0] v);
			fmt = v;
			clear();
		endfunction

		function void add_point(int unsigned ang, int unsigned d, int unsigned q, bit ns);
			scan_point_t p;
			if (prev_ok && prev_ang > ang && (prev_ang - ang) * 2 > FULL_CIRCLE_Q6)
				ns = 1;
			prev_ang = ang;
			prev_ok = 1;
			if (ns)
				rev_cnt = 0;
			if (rev_cnt < 16'hFFFF)
				rev_cnt++;
			p.angle = ang; p.distance = d; p.qual = q; p.nscan = ns;
			p.rev_pts = rev_cnt; p.fails = fail_cnt; p.last = 0;
			expected_points.push_back(p);
		endfunction

		function void standard_byte(logic [7:0] b);
			logic [7:0] b0, b1, b2, b3, b4;
			window = {window[31:0], b};
			if (nfill < 5)
				nfill++;
			if (nfill < 5)
				return;
			{b0, b1, b2, b3, b4} = window;
			if (!b1[0] || b0[0] == b0[1])
				return;
			add_point((32'({b2, b1}) >> 1) % FULL_CIRCLE_Q6, {b4, b3}, b0[7:2], b0[0]);
			nfill = 0;
		endfunction

		function void dense_byte(logic [7:0] b);
			int unsigned k, st, diff, a;
			bit sy;
			if (cfill == 0) begin
				if (b[7:4] == HDR_SYNC1) begin
					hdr = b;
					cfill = 1;
				end
				return;
			end
			if (cfill == 1) begin
				if (b[7:4] == HDR_SYNC2) begin
					hdr = (hdr & 8'hFF) | (b << 8);
					cxor = 0;
					cfill = 2;
				end else if (b[7:4] == HDR_SYNC1)
					hdr = b;
				else
					cfill = 0;
				return;
			end
			cxor ^= b;
			if (cfill == 2)
				cstart = b;
			else if (cfill == 3)
				cstart = (cstart & 8'hFF) | (b << 8);
			else begin
				k = (cfill - 4) >> 1;
				if (k < POINTS_PER_CAPSULE) begin
					if (cfill % 2 == 0)
						incoming[k] = b;
					else
						incoming[k] = (incoming[k] & 8'hFF) | (b << 8);
				end
			end
			cfill++;
			if (cfill < CAPSULE_BYTES)
				return;
			cfill = 0;
			if (cxor != ({hdr[11:8], hdr[3:0]})) begin
				if (fail_cnt < 16'hFFFF)
					fail_cnt++;
				return;
			end
			if (good_cnt < 16'hFFFF)
				good_cnt++;
			st = (cstart & 16'h7FFF) % FULL_CIRCLE_Q6;
			sy = cstart[15];
			if (sy)
				pend_ok = 0;
			if (pend_ok) begin
				diff = (st >= pend_start) ? st - pend_start
					: st + FULL_CIRCLE_Q6 - pend_start;
				for (int i = 0; i < POINTS_PER_CAPSULE; i++) begin
					a = pend_start + (diff * i) / POINTS_PER_CAPSULE;
					if (a >= FULL_CIRCLE_Q6)
						a -= FULL_CIRCLE_Q6;
					add_point(a, pend_dist[i] * 4, 0, pend_sync && i == 0);
				end
			end
			pend_dist = incoming;
			pend_start = st;
			pend_sync = sy;
			pend_ok = 1;
		endfunction

		function void note_byte(logic [7:0] b);
			int n0;
			n0 = expected_points.size();
			if (fmt == FMT_STANDARD)
				standard_byte(b);
			else if (fmt == FMT_DENSE)
				dense_byte(b);
			if (expected_points.size() > n0)
				expected_points[$].last = 1;
		endfunction

		function void check_point(scan_point_t got);
			scan_point_t e;
			if (expected_points.size() == 0) begin
				$error("unexpected point angle %0d", got.angle);
				errors++;
				return;
			end
			e = expected_points.pop_front();
			if (got.angle !== e.angle) begin
				$error("angle_q6 exp %0d got %0d", e.angle, got.angle); errors++;
			end
			if (got.distance !== e.distance) begin
				$error("distance_q2 exp %0d got %0d", e.distance, got.distance); errors++;
			end
			if (got.qual !== e.qual) begin
				$error("quality exp %0d got %0d", e.qual, got.qual); errors++;
			end
			if (got.nscan !== e.nscan) begin
				$error("new_scan exp %0d got %0d", e.nscan, got.nscan); errors++;
			end
			if (got.rev_pts !== e.rev_pts) begin
				$error("points_in_revolution exp %0d got %0d", e.rev_pts, got.rev_pts);
				errors++;
			end
			if (got.fails !== e.fails) begin
				$error("checksum_fail_count exp %0d got %0d", e.fails, got.fails);
				errors++;
			end
			if (got.last !== e.last) begin
				$error("last_of_run exp %0d got %0d", e.last, got.last); errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_wdata = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic [7:0] rx_byte = 0;
	logic [14:0] angle_q6;
	logic [17:0] distance_q2;
	logic [5:0] quality;
	logic new_scan, last_of_run;
	logic [15:0] points_in_revolution, checksum_fail_count;

	point_scoreboard sb = new();
	int idle_pct = 19;
	int hold_off = 0;
	int quiet_cycles = 0;
	logic [7:0] byte_queue[$];

	always #5 clk = ~clk;

	lidar_scan_stream_parser_unit DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready), .angle_q6(angle_q6),
		.distance_q2(distance_q2), .quality(quality), .new_scan(new_scan),
		.points_in_revolution(points_in_revolution),
		.checksum_fail_count(checksum_fail_count), .last_of_run(last_of_run)
	);

	// receiver side
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_point({angle_q6, distance_q2, quality, new_scan,
				points_in_revolution, checksum_fail_count, last_of_run});
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 0;
		end else
			out_ready <= ($urandom_range(99) >= idle_pct);
	end

	// watchdog on accepted beats
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("lidar_scan_stream_parser_unit verification failed");
			$finish;
		end
	end

	task automatic send_byte(logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_byte(b);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.expected_points.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_format(logic [1:0] v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_format(v);
	endtask

	task automatic push_capsule(logic [15:0] start, bit good);
		logic [7:0] c[CAPSULE_BYTES];
		logic [7:0] x;
		x = 0;
		c[0] = {HDR_SYNC1, 4'h0};
		c[1] = {HDR_SYNC2, 4'h0};
		c[2] = start[7:0];
		c[3] = start[15:8];
		for (int i = 4; i < CAPSULE_BYTES; i++)
			c[i] = $urandom;
		for (int i = 2; i < CAPSULE_BYTES; i++)
			x ^= c[i];
		if (!good)
			x = ~x;
		c[0][3:0] = x[3:0];
		c[1][3:0] = x[7:4];
		foreach (c[i])
			byte_queue.push_back(c[i]);
	endtask

	task automatic push_node(logic [5:0] q, bit s, logic [14:0] ang, logic [15:0] d);
		byte_queue.push_back({q, ~s, s});
		byte_queue.push_back({ang[6:0], 1'b1});
		byte_queue.push_back(ang[14:7]);
		byte_queue.push_back(d[7:0]);
		byte_queue.push_back(d[15:8]);
	endtask

	task automatic send_queue();
		while (byte_queue.size() != 0)
			send_byte(byte_queue.pop_front());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// ignored bytes in formats 0 and 3
		send_byte(8'hA5); send_byte(8'h00);
		set_format(2'd3);
		send_byte(8'hFF); send_byte(8'h5A);
		// standard directed: extremes, wrap, invalid node
		set_format(FMT_STANDARD);
		push_node(6'h3F, 1, 15'h7FFF, 16'hFFFF);
		push_node(6'h00, 0, 15'd0, 16'h0000);
		push_node(6'h15, 0, 15'd22000, 16'h1234);
		push_node(6'h2A, 0, 15'd100, 16'h8000);
		byte_queue.push_back(8'h03); // bad sync bits, slides
		send_queue();
		// standard random with no idling on either side
		idle_pct = 0;
		for (int n = 0; n < 12; n++) begin
			if ($urandom_range(9) < 8)
				push_node($urandom, $urandom_range(9) == 0, $urandom, $urandom);
			else
				byte_queue.push_back($urandom);
		end
		send_queue();
		idle_pct = 19;
		// dense directed: header hunt, sync capsule, checksum failure
		set_format(FMT_DENSE);
		byte_queue.push_back(8'hA3); byte_queue.push_back(8'hA7);
		byte_queue.push_back(8'h12);
		push_capsule(16'h8000 | 16'd22000, 1);
		push_capsule(16'd100, 0);
		send_queue();
		// long receiver stall while the sender keeps going, start wraps the circle
		hold_off = 400;
		push_capsule(16'h7FFF, 1);
		for (int n = 0; n < 8; n++)
			byte_queue.push_back($urandom);
		send_queue();
		// pause until all points are out
		drain();
		set_format(2'd0);
		send_byte(8'hA0);
		drain();
		if (sb.errors == 0)
			$display("lidar_scan_stream_parser_unit verification clean");
		else
			$display("lidar_scan_stream_parser_unit verification failed");
		$finish;
	end
endmodule
